FILE: design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the matrix saddle point finder.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int MAX_DIM_DEF     = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int IN_VALUE_W  = 32;   // element_value field
    localparam int OUT_VALUE_W = 32;   // saddle_value field
    localparam int POS_W       = 3;    // saddle_row / saddle_column fields
    localparam int CFG_W       = 4;    // row_count / column_count registers
    localparam int CFG_IDX_W   = 2;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;   // 32 + 3 + 3 = 38, padded to 5 bytes

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW,
        ST_COL,
        ST_DRAIN,
        ST_EMIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

FILE: design/msp_cmp.sv
// ----------------------------------------------------------------------------
// msp_cmp
// Shared signed compare unit: less-than and equality of two operands.
// ----------------------------------------------------------------------------
module msp_cmp
    import msp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    output t_cmp_res                      o_res
);

    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

FILE: design/matrix_saddle_point_finder.sv
// Flow: R*C beats load, one per cycle; the last one starts a row pass, a column
//   pass, a drain step, a check pass (stalled while a saddle is blocked) and a
//   finish step. The next matrix waits until the last beat is in the output
//   register; the single read port of the element memory and the one shared
//   compare unit set the pace. No input is taken during the scan.
// Sync active-low reset: dims back to 8x8, FSM to load.
// ----------------------------------------------------------------------------
// matrix_saddle_point_finder
// Loads a matrix row-major, finds row maxima and column minima, then reports
// every saddle element in row-major order (or one not-found beat).
// ----------------------------------------------------------------------------
module matrix_saddle_point_finder
    import msp_pkg::*;
#(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] element_value
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] saddle_value,
                                                   // [34:32] saddle_row,
                                                   // [37:35] saddle_column
    output logic                   m_axis_tuser,   // [0] found
    output logic                   m_axis_tlast    // last_result
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int TOT_W  = $clog2(DEPTH + 1);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_row_count, r_col_count;
    logic [CNT_W-1:0] rows_c, cols_c;
    logic [TOT_W-1:0] total;
    logic [IDX_W-1:0] rmax, cmax;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_RESET;
            r_col_count <= DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ROW_COUNT) begin
                r_row_count <= i_cfg_data;
            end else if (i_cfg_index == REG_COL_COUNT) begin
                r_col_count <= i_cfg_data;
            end
        end
    end

    // zero acts as one, anything above MAX_DIM as MAX_DIM
    always_comb begin
        if (r_row_count == '0) begin
            rows_c = CNT_W'(1);
        end else if (r_row_count > CFG_W'(MAX_DIM)) begin
            rows_c = CNT_W'(MAX_DIM);
        end else begin
            rows_c = CNT_W'(r_row_count);
        end
        if (r_col_count == '0) begin
            cols_c = CNT_W'(1);
        end else if (r_col_count > CFG_W'(MAX_DIM)) begin
            cols_c = CNT_W'(MAX_DIM);
        end else begin
            cols_c = CNT_W'(r_col_count);
        end
        total = TOT_W'(TOT_W'(rows_c) * TOT_W'(cols_c));
        rmax  = IDX_W'(rows_c - CNT_W'(1));
        cmax  = IDX_W'(cols_c - CNT_W'(1));
    end

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_load_cnt;
    logic [IDX_W-1:0]  r_i, r_j, n_i, n_j;

    logic signed [VALUE_WIDTH-1:0] r_store [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_row_max [MAX_DIM];
    logic signed [VALUE_WIDTH-1:0] r_col_min [MAX_DIM];

    // read pipeline
    logic                          r_rd_valid, r_rd_first, r_rd_last, r_rd_col;
    logic [IDX_W-1:0]              r_rd_line;
    logic signed [VALUE_WIDTH-1:0] r_rd_data;
    logic signed [VALUE_WIDTH-1:0] r_acc, acc_new;

    // pending saddle and output register
    logic                          r_pend_valid;
    logic signed [OUT_VALUE_W-1:0] r_pend_val;
    logic [POS_W-1:0]              r_pend_row, r_pend_col;
    logic                          r_out_valid, r_out_found, r_out_last;
    logic signed [OUT_VALUE_W-1:0] r_out_val;
    logic [POS_W-1:0]              r_out_row, r_out_col;

    // control
    logic                          in_accept, load_end, at_end;
    logic                          issue, issue_col, issue_first, issue_last;
    logic [IDX_W-1:0]              issue_line;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          out_busy, hit, step_ok, push_mid, capture, finish_load;
    logic signed [IN_VALUE_W-1:0]  in_elem;
    logic signed [VALUE_WIDTH-1:0] in_val, emit_val, cmp_a, cmp_b;
    t_cmp_res                      cmp;

    assign in_elem   = s_axis_tdata[IN_VALUE_W-1:0];
    assign in_val    = VALUE_WIDTH'(in_elem);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign load_end  = ((TOT_W+1)'(r_load_cnt) + (TOT_W+1)'(1)) >= (TOT_W+1)'(total);
    assign at_end    = (r_i == rmax) && (r_j == cmax);
    assign rd_addr   = ADDR_W'(ADDR_W'(r_i) * ADDR_W'(cols_c) + ADDR_W'(r_j));
    assign emit_val  = r_row_max[r_i];
    assign out_busy  = r_out_valid && !m_axis_tready;

    // ---------------- shared compare unit ----------------
    always_comb begin
        if (r_state == ST_EMIT) begin
            // col_min <= element <= row_max, so equality of the two marks a saddle
            cmp_a = r_col_min[r_j];
            cmp_b = emit_val;
        end else if (r_rd_col) begin
            cmp_a = r_rd_data;
            cmp_b = r_acc;
        end else begin
            cmp_a = r_acc;
            cmp_b = r_rd_data;
        end
    end

    msp_cmp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp)
    );

    always_comb begin
        if (r_rd_first || cmp.lt) begin
            acc_new = r_rd_data;
        end else begin
            acc_new = r_acc;
        end
    end

    assign hit         = (r_state == ST_EMIT) && cmp.eq;
    assign step_ok     = !(hit && r_pend_valid && out_busy);
    assign push_mid    = hit && r_pend_valid && !out_busy;
    assign capture     = hit && step_ok;
    assign finish_load = (r_state == ST_FINISH) && !out_busy;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:   if (in_accept && load_end) n_state = ST_ROW;
            ST_ROW:    if (at_end) n_state = ST_COL;
            ST_COL:    if (at_end) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_EMIT;
            ST_EMIT:   if (step_ok && at_end) n_state = ST_FINISH;
            ST_FINISH: if (!out_busy) n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        issue_col     = 1'b0;
        issue_first   = 1'b0;
        issue_last    = 1'b0;
        issue_line    = r_i;
        n_i           = r_i;
        n_j           = r_j;
        unique case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                n_i           = '0;
                n_j           = '0;
            end
            ST_ROW: begin
                issue       = 1'b1;
                issue_first = (r_j == '0);
                issue_last  = (r_j == cmax);
                issue_line  = r_i;
                if (at_end) begin
                    n_i = '0;
                    n_j = '0;
                end else if (r_j == cmax) begin
                    n_i = r_i + IDX_W'(1);
                    n_j = '0;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            ST_COL: begin
                issue       = 1'b1;
                issue_col   = 1'b1;
                issue_first = (r_i == '0);
                issue_last  = (r_i == rmax);
                issue_line  = r_j;
                if (at_end) begin
                    n_i = '0;
                    n_j = '0;
                end else if (r_i == rmax) begin
                    n_j = r_j + IDX_W'(1);
                    n_i = '0;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (step_ok) begin
                    if (at_end) begin
                        n_i = '0;
                        n_j = '0;
                    end else if (r_j == cmax) begin
                        n_i = r_i + IDX_W'(1);
                        n_j = '0;
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN, ST_FINISH: begin
                n_i = '0;
                n_j = '0;
            end
            default: begin
                n_i = '0;
                n_j = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_rd_valid <= issue;
            if (in_accept) begin
                r_load_cnt <= load_end ? '0 : r_load_cnt + ADDR_W'(1);
            end
        end
    end

    // element memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_store[r_load_cnt] <= in_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= issue_first;
        r_rd_last  <= issue_last;
        r_rd_col   <= issue_col;
        r_rd_line  <= issue_line;
        if (r_rd_valid) begin
            r_acc <= acc_new;
            if (r_rd_last) begin
                if (r_rd_col) begin
                    r_col_min[r_rd_line] <= acc_new;
                end else begin
                    r_row_max[r_rd_line] <= acc_new;
                end
            end
        end
    end

    // pending saddle is held back until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (capture) begin
            r_pend_valid <= 1'b1;
        end else if (finish_load) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_pend_val <= OUT_VALUE_W'(emit_val);
            r_pend_row <= POS_W'(r_i);
            r_pend_col <= POS_W'(r_j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_mid || finish_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_mid) begin
            r_out_val   <= r_pend_val;
            r_out_row   <= r_pend_row;
            r_out_col   <= r_pend_col;
            r_out_found <= 1'b1;
            r_out_last  <= 1'b0;
        end else if (finish_load) begin
            r_out_last <= 1'b1;
            if (r_pend_valid) begin
                r_out_val   <= r_pend_val;
                r_out_row   <= r_pend_row;
                r_out_col   <= r_pend_col;
                r_out_found <= 1'b1;
            end else begin
                r_out_val   <= '0;
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_found <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_VALUE_W - 2*POS_W)'(0),
                            r_out_col, r_out_row, r_out_val};
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_finish_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish_load |=> (r_state == ST_LOAD) && m_axis_tvalid && m_axis_tlast)
        else $error("finish did not deliver a last beat");

    a_notfound_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("not-found beat without last");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == ST_ROW || r_state == ST_COL || r_state == ST_DRAIN))
        else $error("memory read data outside the scan");

    a_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit && r_pend_valid && out_busy) |=> $stable(r_i) && $stable(r_j))
        else $error("check advanced while a saddle was blocked");

endmodule
